/* sv/sffrp_pkg.sv */
// ---------------------------------------------------------------------------
// sffrp_pkg: shared types and constants of the shelf first-fit placer
// Register map, reset values, shelf entry layout and the state encoding.
// ---------------------------------------------------------------------------
package sffrp_pkg;

	localparam int unsigned MaxShelvesDef = 64;
	localparam int unsigned DimW = 16;
	localparam int unsigned KindW = 8;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [DimW-1:0] BinWidthRst = 16'd1024;
	localparam logic [DimW-1:0] BinHeightRst = 16'd1024;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BIN_WIDTH  = 2'd0,
		REG_BIN_HEIGHT = 2'd1,
		REG_ROTATE     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	// fill never passes the bin_width in force when it is written, so 16 bits hold it
	typedef struct packed {
		logic [DimW-1:0] base;
		logic [DimW-1:0] height;
		logic [DimW-1:0] fill;
	} shelf_t;

endpackage

/* sv/shelf_first_fit_rect_placer_core.sv */
// ---------------------------------------------------------------------------
// shelf_first_fit_rect_placer_core: shelf first-fit rectangle placer
// Flow: an accepted request scans the open shelves in order, reading one shelf
//   entry from memory per cycle, until a fit, a bad size or the last shelf.
// Throughput: one word at a time; the next request is taken the cycle after
//   the result is registered.
// Reset: shelf count, next free y and handshake state clear; the shelf memory
//   is not cleared, entries at or above the count are never used.
// ---------------------------------------------------------------------------
module shelf_first_fit_rect_placer_core
	import sffrp_pkg::*;
#(
	parameter int unsigned MAX_SHELVES = MaxShelvesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DimW-1:0]    cfg_data,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [DimW-1:0]    rect_w,
	input  logic [DimW-1:0]    rect_h,
	input  logic               rot_tag,
	input  logic [KindW-1:0]   kind_tag,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic               placed,
	output logic [DimW-1:0]    pos_x,
	output logic [DimW-1:0]    pos_y,
	output logic               rot_out,
	output logic [KindW-1:0]   kind_out
);

	// index into the shelf memory, and a count that can also hold the depth
	localparam int unsigned IW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
	localparam int unsigned CW = $clog2(MAX_SHELVES + 1) > IW ?
		$clog2(MAX_SHELVES + 1) : IW + 1;
	localparam logic [CW-1:0] CountMax = CW'(MAX_SHELVES);

	// configuration registers
	logic [DimW-1:0] bin_w_q;
	logic [DimW-1:0] bin_h_q;
	logic            rot_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_w_q  <= BinWidthRst;
			bin_h_q  <= BinHeightRst;
			rot_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIN_WIDTH:  bin_w_q  <= cfg_data;
				REG_BIN_HEIGHT: bin_h_q  <= cfg_data;
				REG_ROTATE:     rot_en_q <= cfg_data[0];
				default:        ;  // unmapped index, write dropped
			endcase
		end
	end

	// control state
	state_t          state_q;
	logic [IW-1:0]   idx_q;
	logic [CW-1:0]   count_q;
	logic [DimW-1:0] nfy_q;      // next free y; within bin_height when written

	// latched request
	logic [DimW-1:0]  w_q;
	logic [DimW-1:0]  h_q;
	logic             rot_q;
	logic [KindW-1:0] kind_q;

	// shelf memory: one write port, one registered read port
	shelf_t          shelf_mem [MAX_SHELVES];
	shelf_t          rd_q;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	shelf_t          wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			shelf_mem[wr_addr] <= wr_data;
		end
		rd_q <= shelf_mem[rd_addr];
	end

	// result register
	logic             res_valid_q;
	logic             placed_q;
	logic [DimW-1:0]  pos_x_q;
	logic [DimW-1:0]  pos_y_q;
	logic             rot_out_q;
	logic [KindW-1:0] kind_out_q;

	logic req_take;
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;

	// scan step: rd_q holds shelf idx_q while in ST_SCAN
	logic            bad;
	logic            in_range;
	logic [DimW:0]   fill_sum;
	logic            fit;
	logic [CW-1:0]   idx_nxt;
	logic            last;
	logic [DimW:0]   nfy_sum;
	logic            new_ok;
	logic            finish;
	logic            take;
	logic            out_busy;

	always_comb begin
		bad      = (w_q == '0) || (h_q == '0) || (w_q > bin_w_q) || (h_q > bin_h_q);
		in_range = CW'(idx_q) < count_q;
		fill_sum = {1'b0, rd_q.fill} + {1'b0, w_q};
		fit      = in_range && (h_q <= rd_q.height) && (fill_sum <= {1'b0, bin_w_q});
		idx_nxt  = CW'(idx_q) + CW'(1);
		last     = idx_nxt >= count_q;   // also true for an empty table
		nfy_sum  = {1'b0, nfy_q} + {1'b0, h_q};
		new_ok   = (count_q < CountMax) && (nfy_sum <= {1'b0, bin_h_q});
		finish   = bad || fit || last;
		out_busy = res_valid_q && res_stall;
		take     = (state_q == ST_SCAN) && finish && !out_busy;
	end

	// read address: shelf 0 on accept, next shelf while scanning, else hold
	always_comb begin
		rd_addr = idx_q;
		if (state_q == ST_IDLE) begin
			rd_addr = '0;
		end else if (!finish) begin
			rd_addr = idx_nxt[IW-1:0];
		end
	end

	// write back: grown fill of the hit shelf, or a freshly opened shelf
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		if (take && !bad) begin
			if (fit) begin
				wr_en        = 1'b1;
				wr_data.fill = fill_sum[DimW-1:0];
			end else if (new_ok) begin
				wr_en          = 1'b1;
				wr_addr        = count_q[IW-1:0];
				wr_data.base   = nfy_q;
				wr_data.height = h_q;
				wr_data.fill   = w_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			w_q    <= rect_w;
			h_q    <= rect_h;
			rot_q  <= rot_tag;
			kind_q <= kind_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			count_q <= '0;
			nfy_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (!finish) begin
						idx_q <= idx_nxt[IW-1:0];
					end else if (take) begin
						state_q <= ST_IDLE;
						if (!bad && !fit && new_ok) begin
							count_q <= count_q + CW'(1);
							nfy_q   <= nfy_sum[DimW-1:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rot_out_q  <= rot_q & rot_en_q;
			kind_out_q <= kind_q;
			if (!bad && fit) begin
				placed_q <= 1'b1;
				pos_x_q  <= rd_q.fill;
				pos_y_q  <= rd_q.base;
			end else if (!bad && new_ok) begin
				placed_q <= 1'b1;
				pos_x_q  <= '0;
				pos_y_q  <= nfy_q;
			end else begin
				placed_q <= 1'b0;
				pos_x_q  <= '0;
				pos_y_q  <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign placed    = placed_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign rot_out   = rot_out_q;
	assign kind_out  = kind_out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountMax)
		else $error("shelf count past table depth");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(idx_q) < count_q || count_q == '0))
		else $error("scan index beyond open shelves");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == ST_SCAN))
		else $error("accepted word did not start a scan");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !placed_q) |-> (pos_x_q == '0 && pos_y_q == '0))
		else $error("unplaced word carries a position");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !(res_valid_q && res_stall))
		else $error("result register overwritten while stalled");
`endif

endmodule

/* tb/placement_checker.sv */
// ---------------------------------------------------------------------------
// placement_checker: result checker for the shelf first-fit placer
// Follows config writes and accepted request words, predicts each placement
// from its own copy of the shelf table, and compares every result word,
// field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
module placement_checker
	import sffrp_pkg::*;
#(
	parameter int unsigned MAX_SHELVES = MaxShelvesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DimW-1:0]    cfg_data,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [DimW-1:0]    rect_w,
	input  logic [DimW-1:0]    rect_h,
	input  logic               rot_tag,
	input  logic [KindW-1:0]   kind_tag,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic               placed,
	input  logic [DimW-1:0]    pos_x,
	input  logic [DimW-1:0]    pos_y,
	input  logic               rot_out,
	input  logic [KindW-1:0]   kind_out,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic             placed;
		logic [DimW-1:0]  x;
		logic [DimW-1:0]  y;
		logic             rot;
		logic [KindW-1:0] kind;
	} placement_t;

	placement_t expected_placements[$];

	// register copies
	int unsigned bin_w;
	int unsigned bin_h;
	logic        rot_en;

	// shelf table copy; fill kept wide so the sum with a width never wraps
	int unsigned shelf_base_y[MAX_SHELVES];
	int unsigned shelf_ht[MAX_SHELVES];
	int unsigned shelf_fill_x[MAX_SHELVES];
	int unsigned shelves_open;
	int unsigned free_y;

	// first fit over the open shelves, else a new shelf on top
	function automatic placement_t place_rect(input int unsigned w, input int unsigned h,
			input logic rot, input logic [KindW-1:0] kind);
		placement_t p;
		int unsigned i;
		p.placed = 1'b0;
		p.x = '0;
		p.y = '0;
		p.rot = rot & rot_en;
		p.kind = kind;
		if (w != 0 && h != 0 && w <= bin_w && h <= bin_h) begin
			for (i = 0; i < shelves_open && !p.placed; i++) begin
				if (h <= shelf_ht[i] && shelf_fill_x[i] + w <= bin_w) begin
					p.placed = 1'b1;
					p.x = DimW'(shelf_fill_x[i]);
					p.y = DimW'(shelf_base_y[i]);
					shelf_fill_x[i] = shelf_fill_x[i] + w;
				end
			end
			if (!p.placed && shelves_open < MAX_SHELVES && free_y + h <= bin_h) begin
				shelf_base_y[shelves_open] = free_y;
				shelf_ht[shelves_open] = h;
				shelf_fill_x[shelves_open] = w;
				p.placed = 1'b1;
				p.x = '0;
				p.y = DimW'(free_y);
				free_y = free_y + h;
				shelves_open = shelves_open + 1;
			end
		end
		return p;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count = fail_count + 1;
			$display("%0t  %s: expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		placement_t got;
		placement_t want;
		if (!arst_n) begin
			bin_w = 32'(BinWidthRst);
			bin_h = 32'(BinHeightRst);
			rot_en = 1'b0;
			shelves_open = 0;
			free_y = 0;
			fail_count = 0;
			pending = 0;
			expected_placements.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BIN_WIDTH:  bin_w = 32'(cfg_data);
					REG_BIN_HEIGHT: bin_h = 32'(cfg_data);
					REG_ROTATE:     rot_en = cfg_data[0];
					default:        ;
				endcase
			end
			if (res_valid && !res_stall) begin
				got = '{placed, pos_x, pos_y, rot_out, kind_out};
				if (expected_placements.size() == 0) begin
					fail_count = fail_count + 1;
					$display("%0t  result word with none expected: placed %0d x %0d y %0d",
						$time, got.placed, got.x, got.y);
				end else begin
					want = expected_placements.pop_front();
					check_field("placed", 32'(want.placed), 32'(got.placed));
					check_field("pos_x", 32'(want.x), 32'(got.x));
					check_field("pos_y", 32'(want.y), 32'(got.y));
					check_field("rot_out", 32'(want.rot), 32'(got.rot));
					check_field("kind_out", 32'(want.kind), 32'(got.kind));
				end
			end
			if (req_valid && !req_stall)
				expected_placements.insert(expected_placements.size(),
					place_rect(32'(rect_w), 32'(rect_h), rot_tag, kind_tag));
			pending = expected_placements.size();
		end
	end

endmodule

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: top of the shelf first-fit placer testbench
// Drives config writes and rectangle request words with random gaps and
// result stalls, one long result hold-off, and leaves prediction and
// comparison to placement_checker; prints the verdict at the end.
// ---------------------------------------------------------------------------
module testbench;
	import sffrp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// index outside the register map; the block must ignore writes to it
	localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
	// idle cycles with no word moving before the run is called hung:
	// covers the worst scan, the longest result hold-off and the longest gap, with margin
	localparam int WatchdogLimit = 2000;
	localparam int NumPhases = 8;
	localparam int HoldOffCycles = 300;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [DimW-1:0]    cfg_data;
	logic               req_valid;
	logic               req_stall;
	logic [DimW-1:0]    rect_w;
	logic [DimW-1:0]    rect_h;
	logic               rot_tag;
	logic [KindW-1:0]   kind_tag;
	logic               res_valid;
	logic               res_stall;
	logic               placed;
	logic [DimW-1:0]    pos_x;
	logic [DimW-1:0]    pos_y;
	logic               rot_out;
	logic [KindW-1:0]   kind_out;

	int fail_count;
	int pending;
	int idle_cycles;
	bit hold_off_req;

	shelf_first_fit_rect_placer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rect_w    (rect_w),
		.rect_h    (rect_h),
		.rot_tag   (rot_tag),
		.kind_tag  (kind_tag),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.placed    (placed),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.rot_out   (rot_out),
		.kind_out  (kind_out)
	);

	placement_checker check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.rot_tag    (rot_tag),
		.kind_tag   (kind_tag),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.placed     (placed),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.rot_out    (rot_out),
		.kind_out   (kind_out),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: any moving word (or reset) clears the count.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---- result side: random stalls, plus one long hold-off on request ----
	// Each pass sets a level and keeps it for a run of cycles, so res_stall
	// gets at most one assignment per falling edge.
	initial begin : result_side
		int  run;
		int  pick;
		bit  level;
		bit  hold_done;
		res_stall = 1'b0;
		hold_done = 1'b0;
		@(negedge clk);
		forever begin
			pick = $urandom_range(0, 9);
			if (hold_off_req && !hold_done) begin
				// long hold-off: the block fills and must stall its request side
				hold_done = 1'b1;
				level = 1'b1;
				run = HoldOffCycles;
			end else if (pick <= 4) begin
				level = 1'b0;
				run = $urandom_range(1, 4);
			end else if (pick <= 6) begin
				// stretch with no stalls at all
				level = 1'b0;
				run = $urandom_range(20, 80);
			end else if (pick <= 8) begin
				level = 1'b1;
				run = $urandom_range(1, 3);
			end else begin
				level = 1'b1;
				run = $urandom_range(10, 40);
			end
			res_stall <= level;
			repeat (run) @(negedge clk);
		end
	end

	// ---- request side helpers; all enter and leave on a falling edge ----

	// One config write; the enable drops on the next falling edge.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one request word after a random gap, hold it until taken.
	// Valid stays high after acceptance so back-to-back words need no
	// second assignment in the same step.
	task automatic send_rect(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
			input logic rot, input logic [KindW-1:0] kind);
		int pick;
		int gap;
		pick = $urandom_range(0, 15);
		if (pick <= 9)
			gap = 0;
		else if (pick <= 13)
			gap = $urandom_range(1, 3);
		else if (pick == 14)
			gap = $urandom_range(4, 8);
		else
			gap = $urandom_range(15, 40);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rect_w <= w;
		rect_h <= h;
		rot_tag <= rot;
		kind_tag <= kind;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result word has come back.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Mostly well-formed rectangles scaled to the bin; the rest is noise:
	// zero sizes, full 16-bit sizes, and sizes beyond the bin.
	task automatic send_random_rect(input int unsigned bw, input int unsigned div);
		int unsigned w;
		int unsigned h;
		int unsigned wmax;
		int pick;
		wmax = (bw / div > 0) ? bw / div : 1;
		w = $urandom_range(1, wmax);
		h = $urandom_range(1, 200);
		pick = $urandom_range(0, 19);
		case (pick) inside
			0: begin
				if ($urandom_range(0, 1))
					w = 0;
				else
					h = 0;
			end
			[1:2]: begin
				w = $urandom & 16'hFFFF;
				h = $urandom & 16'hFFFF;
			end
			3: begin
				if (bw < 65535)
					w = $urandom_range(bw + 1, 65535);
				else
					h = $urandom_range(201, 65535);
			end
			default: ;
		endcase
		send_rect(DimW'(w), DimW'(h), 1'($urandom_range(0, 1)),
			KindW'($urandom_range(0, 255)));
	endtask

	// ---- stimulus ----
	initial begin : stimulus
		// per phase: bin width / height (0 = random), rotate (2 = random),
		// width divisor for well-formed rectangles, number of words
		static int unsigned phase_bw[NumPhases]  = '{48, 300, 1024, 8192, 0, 0, 65535, 65535};
		static int unsigned phase_bh[NumPhases]  = '{30000, 30000, 30000, 1024, 0, 0, 65535,
			65535};
		static int unsigned phase_rot[NumPhases] = '{1, 0, 1, 1, 2, 2, 0, 2};
		static int unsigned phase_div[NumPhases] = '{3, 4, 12, 12, 12, 12, 64, 12};
		static int unsigned phase_len[NumPhases] = '{300, 150, 200, 150, 200, 200, 200, 200};
		int unsigned bw;
		int unsigned bh;
		int unsigned rot;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BIN_WIDTH;
		cfg_data = '0;
		req_valid = 1'b0;
		rect_w = '0;
		rect_h = '0;
		rot_tag = 1'b0;
		kind_tag = '0;
		hold_off_req = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset config 1024 x 1024, rotation off.
		send_rect(0, 5, 1'b1, 8'h00);            // zero width
		send_rect(5, 0, 1'b0, 8'hFF);            // zero height
		send_rect(1025, 1, 1'b1, 8'h01);         // wider than the bin
		send_rect(1, 1025, 1'b0, 8'h02);         // taller than the bin
		send_rect(1024, 1, 1'b1, 8'h03);         // exactly fills a shelf
		send_rect(1, 1, 1'b0, 8'h04);            // opens a second shelf
		send_rect(3, 5, 1'b1, 8'h05);            // third shelf
		send_rect(7, 3, 1'b0, 8'h06);            // fits the third shelf
		send_rect(1, 1018, 1'b1, 8'h07);         // new shelf would pass the top
		send_rect(1, 1017, 1'b0, 8'h08);         // new shelf reaching the top exactly
		send_rect(2, 1, 1'b1, 8'h09);            // first fit on a lower shelf
		drain();

		// Largest bin, rotation on with junk in the upper data bits.
		write_reg(REG_BIN_WIDTH, 16'hFFFF);
		write_reg(REG_BIN_HEIGHT, 16'hFFFF);
		write_reg(REG_ROTATE, 16'hFFFF);
		write_reg(RegSpare, DimW'($urandom));
		send_rect(16'hFFFF, 16'hFFFF, 1'b1, 8'h0A);
		send_rect(16'hFFFF, 1, 1'b1, 8'h0B);
		send_rect(16'hAAAA, 16'h5555, 1'b0, 8'h0C);
		send_rect(16'h5555, 16'hAAAA, 1'b1, 8'h0D);
		drain();

		// Smallest bin: every shelf already has fill, nothing can go in.
		write_reg(REG_BIN_WIDTH, 16'd1);
		write_reg(REG_BIN_HEIGHT, 16'd1);
		write_reg(REG_ROTATE, 16'h0000);
		send_rect(1, 1, 1'b1, 8'h0E);
		send_rect(2, 1, 1'b0, 8'h0F);
		drain();

		// Random phases. The narrow first phase opens shelves quickly so the
		// shelf table fills up; later phases widen the bin so the full table
		// keeps taking rectangles and the first-fit scan runs deep.
		for (int p = 0; p < NumPhases; p++) begin
			bw = (phase_bw[p] == 0) ? $urandom_range(1, 65535) : phase_bw[p];
			bh = (phase_bh[p] == 0) ? $urandom_range(1, 65535) : phase_bh[p];
			rot = (phase_rot[p] == 2) ? $urandom_range(0, 1) : phase_rot[p];
			write_reg(REG_BIN_WIDTH, DimW'(bw));
			write_reg(REG_BIN_HEIGHT, DimW'(bh));
			write_reg(REG_ROTATE, DimW'(($urandom & 16'hFFFE) | rot));
			if ($urandom_range(0, 3) == 0)
				write_reg(RegSpare, DimW'($urandom));
			if (p == 1)
				hold_off_req = 1'b1;
			for (int n = 0; n < phase_len[p]; n++)
				send_random_rect(bw, phase_div[p]);
			drain();
		end

		// Let any stray result word show up before the verdict.
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
